/* sv/pwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the prefetch way ledger.
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned LINE_SHIFT = 6;
  localparam int unsigned LINE_W     = ADDR_W - LINE_SHIFT;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned STAMP_W    = 48;
  localparam int unsigned WAY_W      = 4;
  localparam int unsigned DEF_SETS   = 2048;
  localparam int unsigned DEF_WAYS   = 16;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_DEMAND = 2'd1,
    MODE_ROLLBK = 2'd2,
    MODE_STATUS = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ADDR_W-1:0]  byte_address;
    logic [CNT_W-1:0]   access_count;
    logic               keep_until_used;
    logic [STAMP_W-1:0] stamp;
  } req_t;

  typedef struct packed {
    logic             done_res;
    logic [WAY_W-1:0] way_index;
    logic [CNT_W-1:0] remaining;
    logic             needs_eviction;
  } res_t;

  typedef struct packed {
    logic [LINE_W-1:0]  tag;
    logic [CNT_W-1:0]   cnt;
    logic               evict;
    logic               used;
    logic [STAMP_W-1:0] stamp;
  } way_ent_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic scan;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
  } stat_t;

endpackage

/* sv/pwl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer: clearing pass, row read, way scan, write back.
// ----------------------------------------------------------------------------
module pwl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pwl_pkg::stat_t stat_i,
  output pwl_pkg::cmd_t  cmd_o,
  output logic          busy_o
);
  import pwl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule

/* sv/pwl_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_dp
// Ledger row memory, free-way memory, way scan and row update.
// ----------------------------------------------------------------------------
module pwl_dp #(
  parameter int unsigned SETS = pwl_pkg::DEF_SETS,
  parameter int unsigned WAYS = pwl_pkg::DEF_WAYS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pwl_pkg::cmd_t  cmd_i,
  input  pwl_pkg::req_t  req_i,
  output pwl_pkg::stat_t stat_o,
  output pwl_pkg::res_t  res_o,
  output logic           res_valid_o
);
  import pwl_pkg::*;

  localparam int unsigned SET_BITS = $clog2(SETS + 1) - 1;
  localparam int unsigned ROWS     = 1 << SET_BITS;
  localparam int unsigned IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int unsigned WAY_IW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned FW_W     = $clog2(WAYS + 1);

  way_ent_t [WAYS-1:0] row_mem [ROWS];
  logic [FW_W-1:0]     fw_mem  [ROWS];

  req_t                req_q;
  way_ent_t [WAYS-1:0] row_q, row_d;
  logic [FW_W-1:0]     fw_q;
  logic [FW_W-1:0]     fw_d;
  logic [IDX_W-1:0]    clr_q;
  logic [WAY_IW-1:0]   scan_q;
  logic [LINE_W-1:0]   line;
  logic [IDX_W-1:0]    set_idx;
  way_ent_t            ent, rst_ent;

  logic                hit_q, free_q, na_q;
  logic [WAY_IW-1:0]   hit_idx_q, free_idx_q, na_idx_q, al_idx_q;
  logic [STAMP_W-1:0]  na_st_q, al_st_q;
  logic                first, m_hit, m_free;

  res_t                res_q, res_d;
  logic                vld_q;
  logic                sel_ok;
  logic [WAY_IW-1:0]   sel;
  way_ent_t            upd;
  logic [CNT_W:0]      sum;
  logic [CNT_W-1:0]    dec;

  assign line    = req_q.byte_address[ADDR_W-1:LINE_SHIFT];
  assign set_idx = line[IDX_W-1:0] & IDX_W'(ROWS - 1);
  assign rst_ent = '{tag: '0, cnt: '0, evict: 1'b1, used: 1'b0, stamp: '0};

  assign stat_o.clr_last  = (clr_q == IDX_W'(ROWS - 1));
  assign stat_o.scan_last = (scan_q == WAY_IW'(WAYS - 1));

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      row_mem[clr_q] <= {WAYS{rst_ent}};
      fw_mem[clr_q]  <= FW_W'(WAYS);
    end else if (cmd_i.wr) begin
      row_mem[set_idx] <= row_d;
      fw_mem[set_idx]  <= fw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      row_q <= row_mem[set_idx];
      fw_q  <= fw_mem[set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      scan_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clr) clr_q <= clr_q + IDX_W'(1);
      if (cmd_i.rd) scan_q <= '0;
      else if (cmd_i.scan) scan_q <= scan_q + WAY_IW'(1);
      vld_q <= cmd_i.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.wr) res_q <= res_d;
  end

  // way scan
  assign ent    = row_q[scan_q];
  assign first  = (scan_q == '0);
  assign m_hit  = (ent.tag == line) && (line != '0);
  assign m_free = (ent.tag == '0) && (ent.cnt == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      if (first || !hit_q) begin
        hit_q     <= m_hit;
        hit_idx_q <= scan_q;
      end
      if (first || !free_q) begin
        free_q     <= m_free;
        free_idx_q <= scan_q;
      end
      if (!ent.used && (first || !na_q || ent.stamp >= na_st_q)) begin
        na_q     <= 1'b1;
        na_idx_q <= scan_q;
        na_st_q  <= ent.stamp;
      end else if (first) begin
        na_q <= 1'b0;
      end
      if (first || ent.stamp > al_st_q) begin
        al_idx_q <= scan_q;
        al_st_q  <= ent.stamp;
      end
    end
  end

  // update and result
  always_comb begin
    row_d  = row_q;
    fw_d   = fw_q;
    res_d  = '0;
    sel_ok = 1'b0;
    sel    = hit_q ? hit_idx_q : free_idx_q;
    upd    = row_q[sel];
    sum    = {1'b0, upd.cnt} + {1'b0, req_q.access_count};
    dec    = (upd.cnt != '0) ? upd.cnt - CNT_W'(1) : '0;
    case (mode_e'(req_q.mode))
      MODE_ALLOC: begin
        sel_ok = (line != '0) && (fw_q != '0) && (hit_q || free_q);
        if (sel_ok) begin
          if (!hit_q) fw_d = fw_q - FW_W'(1);
          upd.tag   = line;
          upd.evict = req_q.keep_until_used;
          upd.stamp = req_q.stamp;
          upd.used  = 1'b0;
          upd.cnt   = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
          row_d[sel]      = upd;
          res_d.done_res  = 1'b1;
          res_d.way_index = WAY_W'(sel);
          res_d.remaining = upd.cnt;
        end
      end
      MODE_DEMAND: begin
        if (hit_q) begin
          upd.cnt   = dec;
          upd.used  = 1'b1;
          upd.stamp = req_q.stamp;
          if (dec == '0) begin
            upd.tag   = '0;
            upd.stamp = '0;
            if (fw_q < FW_W'(WAYS)) fw_d = fw_q + FW_W'(1);
          end
          row_d[sel]      = upd;
          res_d.done_res  = 1'b1;
          res_d.way_index = WAY_W'(sel);
          res_d.remaining = dec;
        end
      end
      MODE_ROLLBK: begin
        res_d.way_index = WAY_W'(na_q ? na_idx_q : al_idx_q);
      end
      MODE_STATUS: begin
        if (hit_q) begin
          res_d.done_res       = 1'b1;
          res_d.way_index      = WAY_W'(sel);
          res_d.remaining      = upd.cnt;
          res_d.needs_eviction = upd.evict;
        end else begin
          res_d.needs_eviction = 1'b1;
        end
      end
      default: res_d = '0;
    endcase
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q;

endmodule

/* sv/prefetch_way_ledger_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefetch_way_ledger_top
// Set-associative ledger of prefetched lines: allocate, demand, rollback
// victim query and status query.
// ----------------------------------------------------------------------------
// channel   signals                    transfer
// request   start_i, busy_o, req_i     start_i high while busy_o low
// result    res_valid_o, res_o         res_valid_o high for one cycle
//
// An item passes the accepting cycle, one row read, one way per cycle through
// the scan, then one write back; busy_o is high from the row read through the
// write back. The result strobes in the cycle after the write back, the same
// cycle in which the next start can be taken. After reset a clearing pass over
// 2**floor(log2(SETS)) rows holds busy_o high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module prefetch_way_ledger_top #(
  parameter int unsigned SETS = pwl_pkg::DEF_SETS,
  parameter int unsigned WAYS = pwl_pkg::DEF_WAYS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pwl_pkg::req_t req_i,
  output logic          res_valid_o,
  output pwl_pkg::res_t res_o
);
  import pwl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pwl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  pwl_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule
